// ===== hw/rtl/fcsm_pkg.sv =====
// Shared types and constants for the fault code status manager.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fcsm_pkg;

   // Field widths of the request, response and register words.
   localparam int MODE_WIDTH      = 3;
   localparam int DTC_INDEX_WIDTH = 4;
   localparam int DATA_WIDTH      = 8;
   localparam int FLAGS_WIDTH     = 6;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int DELTA_WIDTH     = SAMPLE_WIDTH + 1;
   localparam int LIMIT_WIDTH     = 15;
   localparam int TICKS_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Entries past this count can never be addressed by a request word.
   localparam int MAX_ADDRESSABLE = 2 ** DTC_INDEX_WIDTH;

   // Request modes.
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TICK      = 3'd0,
      MODE_READ      = 3'd1,
      MODE_WRITE     = 3'd2,
      MODE_SET       = 3'd3,
      MODE_CLEAR     = 3'd4,
      MODE_CLEAR_ALL = 3'd5
   } mode_type;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTROL_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SENSOR_LEVEL   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATTERY_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_TICKS   = 3'd4;

   // Register reset values (limits are 1/128 volt per LSB).
   localparam logic                           RST_CONTROL_ENABLE = 1'b1;
   localparam logic signed [SAMPLE_WIDTH-1:0] RST_SENSOR_LEVEL   = 16'sd0;
   localparam logic [LIMIT_WIDTH-1:0]         RST_BATTERY_LIMIT  = 15'd1024;
   localparam logic [LIMIT_WIDTH-1:0]         RST_OUTPUT_LIMIT   = 15'd128;
   localparam logic [TICKS_WIDTH-1:0]         RST_FILTER_TICKS   = 16'd1000;

   // Monitored trouble codes.
   localparam int MONITOR_COUNT      = 10;
   localparam int CODE_VOUT_OVER     = 0;
   localparam int CODE_IIN_OVER      = 1;
   localparam int CODE_IIN_SENSOR    = 2;
   localparam int CODE_IOUT_SENSOR   = 3;
   localparam int CODE_TEMP_SENSOR   = 4;
   localparam int CODE_BATTERY_DELTA = 5;
   localparam int CODE_TEMP_OVER     = 6;
   localparam int CODE_OUTPUT_DELTA  = 7;
   localparam int CODE_BUS_OFF       = 8;
   localparam int CODE_BUS_TIMEOUT   = 9;

   // Bit positions within the status flags field.
   localparam int FLAG_VOUT_OVER       = 0;
   localparam int FLAG_IIN_OVER        = 1;
   localparam int FLAG_TEMP_OVER       = 2;
   localparam int FLAG_BUS_OFF         = 3;
   localparam int FLAG_BUS_TIMEOUT     = 4;
   localparam int FLAG_SOFT_START_DONE = 5;

   // Status byte bits.
   localparam logic [DATA_WIDTH-1:0] BIT_TEST_FAILED = 8'h01;
   localparam logic [DATA_WIDTH-1:0] BIT_CONFIRMED   = 8'h08;
   localparam logic [DATA_WIDTH-1:0] FAIL_BITS       = BIT_TEST_FAILED | BIT_CONFIRMED;

   // Controller states.
   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_blocked;
   } dp_status_type;

endpackage

// ===== hw/rtl/fcsm_ctrl.sv =====
// Controller state machine: accepts a request word, then commits it to the datapath.
// Depends on fcsm_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module fcsm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fcsm_pkg::dp_status_type dp_status,
   output fcsm_pkg::dp_cmd_type    dp_cmd
);
   import fcsm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      dp_cmd.capture = 1'b0;
      dp_cmd.commit  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_stall      = reset;
            dp_cmd.capture = req_valid && !reset;
            if (dp_cmd.capture) begin
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            // The update waits until the response register can take its result.
            dp_cmd.commit = !dp_status.out_blocked;
            if (dp_cmd.commit) begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fcsm_datapath.sv =====
// Datapath: request capture, configuration registers, status table, monitors and
// the response register. Depends on fcsm_pkg; driven by commands from fcsm_ctrl.
`timescale 1ns / 1ps

module fcsm_datapath #(
   parameter int TableDepth = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  fcsm_pkg::dp_cmd_type                      dp_cmd,
   output fcsm_pkg::dp_status_type                   dp_status,
   input  logic [fcsm_pkg::MODE_WIDTH-1:0]           req_mode,
   input  logic [fcsm_pkg::DTC_INDEX_WIDTH-1:0]      req_dtc_index,
   input  logic [fcsm_pkg::DATA_WIDTH-1:0]           req_data,
   input  logic [fcsm_pkg::FLAGS_WIDTH-1:0]          req_status_flags,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_input_current,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_output_current,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_temperature,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_battery_voltage,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_output_voltage,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_target_voltage,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [fcsm_pkg::DATA_WIDTH-1:0]           rsp_read_data,
   input  logic                                      csr_write_enable,
   input  logic [fcsm_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [fcsm_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data
);
   import fcsm_pkg::*;

   localparam int IdxBits = $clog2(TableDepth);
   localparam logic [DTC_INDEX_WIDTH:0] DepthLimit = (DTC_INDEX_WIDTH + 1)'(TableDepth);

   // Captured request word.
   logic [MODE_WIDTH-1:0]           mode_ff;
   logic [DTC_INDEX_WIDTH-1:0]      dtc_index_ff;
   logic [DATA_WIDTH-1:0]           data_ff;
   logic [FLAGS_WIDTH-1:0]          flags_ff;
   logic signed [SAMPLE_WIDTH-1:0]  input_current_ff;
   logic signed [SAMPLE_WIDTH-1:0]  output_current_ff;
   logic signed [SAMPLE_WIDTH-1:0]  temperature_ff;
   logic signed [SAMPLE_WIDTH-1:0]  battery_voltage_ff;
   logic signed [SAMPLE_WIDTH-1:0]  output_voltage_ff;
   logic signed [SAMPLE_WIDTH-1:0]  target_voltage_ff;

   // Configuration registers.
   logic                            control_enable_ff;
   logic signed [SAMPLE_WIDTH-1:0]  sensor_level_ff;
   logic [LIMIT_WIDTH-1:0]          battery_limit_ff;
   logic [LIMIT_WIDTH-1:0]          output_limit_ff;
   logic [TICKS_WIDTH-1:0]          filter_ticks_ff;

   // Block state.
   logic [DATA_WIDTH-1:0]  status_table_ff [TableDepth];
   logic [DATA_WIDTH-1:0]  status_table_in [TableDepth];
   logic [TICKS_WIDTH-1:0] mismatch_count_ff;
   logic [TICKS_WIDTH-1:0] mismatch_count_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [DATA_WIDTH-1:0]  rsp_data_ff;
   logic [DATA_WIDTH-1:0]  read_value;

   // Monitor results.
   logic signed [DELTA_WIDTH-1:0] battery_delta;
   logic signed [DELTA_WIDTH-1:0] output_delta;
   logic                          battery_mismatch;
   logic                          output_mismatch;
   logic                          count_below;
   logic [MONITOR_COUNT-1:0]      monitor_fail;
   logic [TableDepth-1:0]         set_vec;
   logic [TableDepth-1:0]         clr_vec;

   function automatic logic beyond(input logic signed [DELTA_WIDTH-1:0] delta,
                                   input logic [LIMIT_WIDTH-1:0] limit);
      logic signed [DELTA_WIDTH-1:0] lim;
      lim = {2'b00, limit};
      return (delta > lim) || (delta < -lim);
   endfunction

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         mode_ff            <= req_mode;
         dtc_index_ff       <= req_dtc_index;
         data_ff            <= req_data;
         flags_ff           <= req_status_flags;
         input_current_ff   <= req_input_current;
         output_current_ff  <= req_output_current;
         temperature_ff     <= req_temperature;
         battery_voltage_ff <= req_battery_voltage;
         output_voltage_ff  <= req_output_voltage;
         target_voltage_ff  <= req_target_voltage;
      end
      if (dp_cmd.commit) begin
         rsp_data_ff <= read_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_enable_ff <= RST_CONTROL_ENABLE;
         sensor_level_ff   <= RST_SENSOR_LEVEL;
         battery_limit_ff  <= RST_BATTERY_LIMIT;
         output_limit_ff   <= RST_OUTPUT_LIMIT;
         filter_ticks_ff   <= RST_FILTER_TICKS;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CONTROL_ENABLE: control_enable_ff <= csr_write_data[0];
            CSR_SENSOR_LEVEL:   sensor_level_ff   <= csr_write_data;
            CSR_BATTERY_LIMIT:  battery_limit_ff  <= csr_write_data[LIMIT_WIDTH-1:0];
            CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_write_data[LIMIT_WIDTH-1:0];
            CSR_FILTER_TICKS:   filter_ticks_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TableDepth; i++) begin
            status_table_ff[i] <= '0;
         end
         mismatch_count_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         status_table_ff   <= status_table_in;
         mismatch_count_ff <= mismatch_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Monitor evaluation for a tick word.
   always_comb begin
      battery_delta    = DELTA_WIDTH'(battery_voltage_ff) - DELTA_WIDTH'(output_voltage_ff);
      output_delta     = DELTA_WIDTH'(target_voltage_ff) - DELTA_WIDTH'(output_voltage_ff);
      battery_mismatch = beyond(battery_delta, battery_limit_ff);
      output_mismatch  = flags_ff[FLAG_SOFT_START_DONE] && beyond(output_delta, output_limit_ff);
      count_below      = mismatch_count_ff < filter_ticks_ff;

      monitor_fail                     = '0;
      monitor_fail[CODE_VOUT_OVER]     = flags_ff[FLAG_VOUT_OVER];
      monitor_fail[CODE_IIN_OVER]      = flags_ff[FLAG_IIN_OVER];
      monitor_fail[CODE_IIN_SENSOR]    = input_current_ff <= sensor_level_ff;
      monitor_fail[CODE_IOUT_SENSOR]   = output_current_ff <= sensor_level_ff;
      monitor_fail[CODE_TEMP_SENSOR]   = temperature_ff <= sensor_level_ff;
      monitor_fail[CODE_BATTERY_DELTA] = battery_mismatch;
      monitor_fail[CODE_TEMP_OVER]     = flags_ff[FLAG_TEMP_OVER];
      monitor_fail[CODE_OUTPUT_DELTA]  = output_mismatch;
      monitor_fail[CODE_BUS_OFF]       = flags_ff[FLAG_BUS_OFF];
      monitor_fail[CODE_BUS_TIMEOUT]   = flags_ff[FLAG_BUS_TIMEOUT];

      set_vec = '0;
      clr_vec = '0;
      for (int i = 0; i < MONITOR_COUNT; i++) begin
         set_vec[i] = monitor_fail[i];
         clr_vec[i] = !monitor_fail[i];
      end
      // The battery code only fails once the filter count has run out.
      set_vec[CODE_BATTERY_DELTA] = battery_mismatch && !count_below;
      clr_vec[CODE_BATTERY_DELTA] = !battery_mismatch;
   end

   // Filter counter runs on every tick, whatever the enable.
   always_comb begin
      mismatch_count_in = mismatch_count_ff;
      if (dp_cmd.commit && (mode_ff == MODE_TICK)) begin
         if (!battery_mismatch) begin
            mismatch_count_in = '0;
         end else if (count_below) begin
            mismatch_count_in = mismatch_count_ff + TICKS_WIDTH'(1);
         end
      end
   end

   always_comb begin : table_update
      logic [DATA_WIDTH-1:0] entry_next;
      logic                  entry_sel;
      for (int i = 0; i < TableDepth; i++) begin
         entry_next = status_table_ff[i];
         entry_sel  = (dtc_index_ff == DTC_INDEX_WIDTH'(i));
         case (mode_ff)
            MODE_TICK: begin
               if (control_enable_ff) begin
                  if (set_vec[i]) begin
                     entry_next = entry_next | FAIL_BITS;
                  end else if (clr_vec[i]) begin
                     entry_next = entry_next & ~BIT_TEST_FAILED;
                  end
               end
            end
            MODE_WRITE: begin
               if (entry_sel) begin
                  entry_next = data_ff;
               end
            end
            MODE_SET: begin
               if (control_enable_ff && entry_sel) begin
                  entry_next = entry_next | data_ff;
               end
            end
            MODE_CLEAR: begin
               if (control_enable_ff && entry_sel) begin
                  entry_next = entry_next & ~data_ff;
               end
            end
            MODE_CLEAR_ALL: begin
               entry_next = '0;
            end
            default: begin
            end
         endcase
         status_table_in[i] = dp_cmd.commit ? entry_next : status_table_ff[i];
      end
   end

   always_comb begin
      read_value = '0;
      if ((mode_ff == MODE_READ) && ({1'b0, dtc_index_ff} < DepthLimit)) begin
         read_value = status_table_ff[dtc_index_ff[IdxBits-1:0]];
      end
   end

   always_comb begin
      dp_status.out_blocked = rsp_valid_ff && rsp_stall;
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== hw/rtl/fault_code_status_manager_core.sv =====
// Fault code status manager: the controller captures a request word, then executes it in its
// execute step, and the response word is registered at the commit; a new word is accepted only
// once the previous one has been committed. A stalled response holds the execute step until
// the response register drains. Synchronous reset clears the status table and the filter counter
// and loads the register defaults at once; there is no clearing pass. Depends on fcsm_pkg,
// fcsm_ctrl, fcsm_datapath.
`timescale 1ns / 1ps

module fault_code_status_manager_core #(
   parameter int CODE_COUNT = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request channel.
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [fcsm_pkg::MODE_WIDTH-1:0]           req_mode,
   input  logic [fcsm_pkg::DTC_INDEX_WIDTH-1:0]      req_dtc_index,
   input  logic [fcsm_pkg::DATA_WIDTH-1:0]           req_data,
   input  logic [fcsm_pkg::FLAGS_WIDTH-1:0]          req_status_flags,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_input_current,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_output_current,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_temperature,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_battery_voltage,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_output_voltage,
   input  logic signed [fcsm_pkg::SAMPLE_WIDTH-1:0]  req_target_voltage,
   // Response channel.
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [fcsm_pkg::DATA_WIDTH-1:0]           rsp_read_data,
   // Configuration write port.
   input  logic                                      csr_write_enable,
   input  logic [fcsm_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [fcsm_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data
);
   import fcsm_pkg::*;

   // A request word carries a four-bit index, so only the first sixteen codes can ever be
   // read or written. Codes beyond that are never touched and need no storage; indexes at
   // or beyond CODE_COUNT read as zero and are ignored by writes.
   localparam int TableDepth = (CODE_COUNT < MAX_ADDRESSABLE) ? CODE_COUNT : MAX_ADDRESSABLE;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences each word through capture and execute.
   fcsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // The datapath holds the table, the monitors, the registers and the response register.
   fcsm_datapath #(
      .TableDepth (TableDepth)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status),
      .req_mode            (req_mode),
      .req_dtc_index       (req_dtc_index),
      .req_data            (req_data),
      .req_status_flags    (req_status_flags),
      .req_input_current   (req_input_current),
      .req_output_current  (req_output_current),
      .req_temperature     (req_temperature),
      .req_battery_voltage (req_battery_voltage),
      .req_output_voltage  (req_output_voltage),
      .req_target_voltage  (req_target_voltage),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

`ifndef NO_ASSERTIONS
   // An accepted word keeps the block busy for the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous word was not yet executed");

   // A commit never overwrites a response that is still waiting to be taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> !(rsp_valid && rsp_stall))
      else $error("commit while the response register is blocked");

   // Every commit produces a response word on the next cycle.
   a_commit_responds: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |=> (rsp_valid && !req_stall))
      else $error("commit did not present a response word");

   // A response word only appears as the result of a commit.
   a_response_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.commit))
      else $error("response word appeared without a commit");
`endif

endmodule

// ===== bench/fault_code_status_manager_core_test.sv =====
// Self-checking bench for the fault code status manager core.
// Depends on fcsm_pkg and fault_code_status_manager_core; it predicts every
// response word from its own copy of the status table and registers.
`timescale 1ns / 1ps

module fault_code_status_manager_core_test;

   import fcsm_pkg::*;

   localparam int TABLE_DEPTH     = 16;
   localparam int WORDS_PER_PHASE = 240;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   // Mode codes that the block must treat as no-operations.
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_B = 3'd7;

   // One request word as the bench keeps it in its queues.
   typedef struct packed {
      logic [MODE_WIDTH-1:0]          mode;
      logic [DTC_INDEX_WIDTH-1:0]     dtc_index;
      logic [DATA_WIDTH-1:0]          data;
      logic [FLAGS_WIDTH-1:0]         status_flags;
      logic signed [SAMPLE_WIDTH-1:0] input_current;
      logic signed [SAMPLE_WIDTH-1:0] output_current;
      logic signed [SAMPLE_WIDTH-1:0] temperature;
      logic signed [SAMPLE_WIDTH-1:0] battery_voltage;
      logic signed [SAMPLE_WIDTH-1:0] output_voltage;
      logic signed [SAMPLE_WIDTH-1:0] target_voltage;
   } request_word_type;

   // Clock, reset and every block input start at known values.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [DATA_WIDTH-1:0]      rsp_read_data;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   request_word_type current_word = '0;
   request_word_type pending_words[$];
   logic [DATA_WIDTH-1:0] expected_read_bytes[$];
   logic [DATA_WIDTH-1:0] oldest_read_byte;

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap_left = 0;
   int  stall_left = 0;
   logic quiet_run = 1'b0;
   logic idling_allowed;

   // Predicted state of the block: the status table, the battery filter
   // counter and a copy of each configuration register at its reset value.
   logic [DATA_WIDTH-1:0]          status_bytes[TABLE_DEPTH];
   logic [TICKS_WIDTH-1:0]         mismatch_ticks = '0;
   logic                           control_enable = RST_CONTROL_ENABLE;
   logic signed [SAMPLE_WIDTH-1:0] sensor_level   = RST_SENSOR_LEVEL;
   logic [LIMIT_WIDTH-1:0]         battery_limit  = RST_BATTERY_LIMIT;
   logic [LIMIT_WIDTH-1:0]         output_limit   = RST_OUTPUT_LIMIT;
   logic [TICKS_WIDTH-1:0]         filter_ticks   = RST_FILTER_TICKS;

   initial begin
      foreach (status_bytes[i]) status_bytes[i] = '0;
   end

   // The request fields follow the word the driver currently offers.
   wire [MODE_WIDTH-1:0] req_mode;
   assign req_mode            = current_word.mode;

   fault_code_status_manager_core #(
      .CODE_COUNT (TABLE_DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_dtc_index       (current_word.dtc_index),
      .req_data            (current_word.data),
      .req_status_flags    (current_word.status_flags),
      .req_input_current   (current_word.input_current),
      .req_output_current  (current_word.output_current),
      .req_temperature     (current_word.temperature),
      .req_battery_voltage (current_word.battery_voltage),
      .req_output_voltage  (current_word.output_voltage),
      .req_target_voltage  (current_word.target_voltage),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Status table prediction.
   // ---------------------------------------------------------------------

   // Set and clear only act while the control enable is on.
   function automatic void set_status_bits(input int index, input logic [DATA_WIDTH-1:0] mask);
      if (control_enable && index < TABLE_DEPTH) begin
         status_bytes[index] = status_bytes[index] | mask;
      end
   endfunction

   function automatic void clear_status_bits(input int index,
                                             input logic [DATA_WIDTH-1:0] mask);
      if (control_enable && index < TABLE_DEPTH) begin
         status_bytes[index] = status_bytes[index] & ~mask;
      end
   endfunction

   // A failing monitor latches test-failed and confirmed; a passing one
   // drops test-failed but keeps confirmed.
   function automatic void update_code(input int code, input logic failing);
      if (failing) begin
         set_status_bits(code, FAIL_BITS);
      end else begin
         clear_status_bits(code, BIT_TEST_FAILED);
      end
   endfunction

   // Deltas are 17 bits wide, so the magnitude check never wraps.
   function automatic logic exceeds(input logic signed [SAMPLE_WIDTH:0] delta,
                                    input logic [LIMIT_WIDTH-1:0] limit);
      logic signed [SAMPLE_WIDTH:0] bound;
      bound = $signed({2'b00, limit});
      return (delta > bound) || (delta < -bound);
   endfunction

   function automatic void run_monitors(input request_word_type w);
      logic signed [SAMPLE_WIDTH:0] battery_delta;
      logic signed [SAMPLE_WIDTH:0] output_delta;
      battery_delta = $signed(w.battery_voltage) - $signed(w.output_voltage);
      output_delta  = $signed(w.target_voltage) - $signed(w.output_voltage);

      update_code(CODE_VOUT_OVER, w.status_flags[FLAG_VOUT_OVER]);
      update_code(CODE_IIN_OVER, w.status_flags[FLAG_IIN_OVER]);
      update_code(CODE_IIN_SENSOR, $signed(w.input_current) <= sensor_level);
      update_code(CODE_IOUT_SENSOR, $signed(w.output_current) <= sensor_level);
      update_code(CODE_TEMP_SENSOR, $signed(w.temperature) <= sensor_level);

      // The battery filter counts whatever the enable; the code only fails
      // once the counter has reached the configured number of ticks.
      if (exceeds(battery_delta, battery_limit)) begin
         if (mismatch_ticks < filter_ticks) begin
            mismatch_ticks = mismatch_ticks + TICKS_WIDTH'(1);
         end else begin
            set_status_bits(CODE_BATTERY_DELTA, FAIL_BITS);
         end
      end else begin
         clear_status_bits(CODE_BATTERY_DELTA, BIT_TEST_FAILED);
         mismatch_ticks = '0;
      end

      update_code(CODE_TEMP_OVER, w.status_flags[FLAG_TEMP_OVER]);
      update_code(CODE_OUTPUT_DELTA, w.status_flags[FLAG_SOFT_START_DONE] &&
                                     exceeds(output_delta, output_limit));
      update_code(CODE_BUS_OFF, w.status_flags[FLAG_BUS_OFF]);
      update_code(CODE_BUS_TIMEOUT, w.status_flags[FLAG_BUS_TIMEOUT]);
   endfunction

   // Applies one accepted word to the predicted state and returns the byte
   // that its response word must carry.
   function automatic logic [DATA_WIDTH-1:0] apply_word_to_table(input request_word_type w);
      logic [DATA_WIDTH-1:0] read_byte;
      read_byte = '0;
      case (w.mode)
         MODE_TICK: begin
            run_monitors(w);
         end
         MODE_READ: begin
            if (w.dtc_index < TABLE_DEPTH) read_byte = status_bytes[w.dtc_index];
         end
         MODE_WRITE: begin
            if (w.dtc_index < TABLE_DEPTH) status_bytes[w.dtc_index] = w.data;
         end
         MODE_SET: begin
            set_status_bits(w.dtc_index, w.data);
         end
         MODE_CLEAR: begin
            clear_status_bits(w.dtc_index, w.data);
         end
         MODE_CLEAR_ALL: begin
            foreach (status_bytes[i]) status_bytes[i] = '0;
         end
         default: begin
         end
      endcase
      return read_byte;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver and response monitor.
   // ---------------------------------------------------------------------

   // Idling is switched off in regular windows and for the last phase.
   assign idling_allowed = !quiet_run && (cycle_count[8:7] != 2'b11);

   // A word is predicted at the edge where it is accepted. A new word is
   // only offered once the previous one has gone, so a stalled word holds.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_read_bytes.push_back(apply_word_to_table(current_word));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap_left != 0) begin
               req_valid <= 1'b0;
               send_gap_left <= send_gap_left - 1;
            end else if (idling_allowed && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               send_gap_left <= $urandom_range(0, 6);
            end else if (pending_words.size() != 0) begin
               current_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Each response word is checked against the oldest prediction; the stall
   // comes in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_read_bytes.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("unexpected response word: read_data %02h", rsp_read_data);
               end
               error_count = error_count + 1;
            end else begin
               oldest_read_byte = expected_read_bytes.pop_front();
               if (rsp_read_data !== oldest_read_byte) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("read_data mismatch: expected %02h, got %02h",
                              oldest_read_byte, rsp_read_data);
                  end
                  error_count = error_count + 1;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (idling_allowed && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // The run is cut off if the traffic ever stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------

   // Registers are written only while nothing is in flight, so the copies
   // can follow at once.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      case (index)
         CSR_CONTROL_ENABLE: control_enable = value[0];
         CSR_SENSOR_LEVEL:   sensor_level = value;
         CSR_BATTERY_LIMIT:  battery_limit = value[LIMIT_WIDTH-1:0];
         CSR_OUTPUT_LIMIT:   output_limit = value[LIMIT_WIDTH-1:0];
         CSR_FILTER_TICKS:   filter_ticks = value;
         default: begin
         end
      endcase
   endtask

   task automatic program_registers(input logic [CSR_DATA_WIDTH-1:0] enable_value,
                                    input logic [CSR_DATA_WIDTH-1:0] level_value,
                                    input logic [CSR_DATA_WIDTH-1:0] battery_value,
                                    input logic [CSR_DATA_WIDTH-1:0] output_value,
                                    input logic [CSR_DATA_WIDTH-1:0] ticks_value);
      write_register(CSR_CONTROL_ENABLE, enable_value);
      write_register(CSR_SENSOR_LEVEL, level_value);
      write_register(CSR_BATTERY_LIMIT, battery_value);
      write_register(CSR_OUTPUT_LIMIT, output_value);
      write_register(CSR_FILTER_TICKS, ticks_value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every queued word has been sent and answered, then lets
   // the block settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_read_bytes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // A table access word; the analog fields are zero.
   task automatic push_access(input logic [MODE_WIDTH-1:0] mode,
                              input logic [DTC_INDEX_WIDTH-1:0] index,
                              input logic [DATA_WIDTH-1:0] data);
      request_word_type w;
      w = '0;
      w.mode = mode;
      w.dtc_index = index;
      w.data = data;
      pending_words.push_back(w);
   endtask

   // A tick word with the same value on all three sensor readings.
   task automatic push_tick(input logic [FLAGS_WIDTH-1:0] flags,
                            input logic signed [SAMPLE_WIDTH-1:0] sensor,
                            input logic signed [SAMPLE_WIDTH-1:0] vbat,
                            input logic signed [SAMPLE_WIDTH-1:0] vout,
                            input logic signed [SAMPLE_WIDTH-1:0] vtgt);
      request_word_type w;
      w = '0;
      w.mode = MODE_TICK;
      w.status_flags = flags;
      w.input_current = sensor;
      w.output_current = sensor;
      w.temperature = sensor;
      w.battery_voltage = vbat;
      w.output_voltage = vout;
      w.target_voltage = vtgt;
      pending_words.push_back(w);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] clip_sample(input int value);
      if (value > 32767) return 16'sh7FFF;
      if (value < -32768) return 16'sh8000;
      return value[SAMPLE_WIDTH-1:0];
   endfunction

   // Half the sensor readings land right around the short threshold.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sensor_sample();
      if ($urandom_range(0, 1) == 1) return SAMPLE_WIDTH'($urandom);
      return clip_sample(int'(sensor_level) + int'($urandom_range(0, 4)) - 2);
   endfunction

   // A delta just inside, on or just beyond a limit, of either sign.
   function automatic int boundary_delta(input logic [LIMIT_WIDTH-1:0] limit);
      int delta;
      delta = int'(limit) + int'($urandom_range(0, 2)) - 1;
      return ($urandom_range(0, 1) == 1) ? delta : -delta;
   endfunction

   function automatic request_word_type random_word();
      request_word_type w;
      int pick;
      int vout;
      pick = $urandom_range(0, 99);
      if (pick < 40)      w.mode = MODE_TICK;
      else if (pick < 70) w.mode = MODE_READ;
      else if (pick < 78) w.mode = MODE_WRITE;
      else if (pick < 86) w.mode = MODE_SET;
      else if (pick < 94) w.mode = MODE_CLEAR;
      else if (pick < 97) w.mode = MODE_CLEAR_ALL;
      else                w.mode = ($urandom_range(0, 1) == 1) ? MODE_SPARE_A : MODE_SPARE_B;
      w.dtc_index = DTC_INDEX_WIDTH'($urandom_range(0, 15));
      w.data = DATA_WIDTH'($urandom_range(0, 255));
      w.status_flags = FLAGS_WIDTH'($urandom_range(0, 63));
      w.input_current = sensor_sample();
      w.output_current = sensor_sample();
      w.temperature = sensor_sample();

      // The output voltage is the reference for both delta monitors.
      vout = int'($urandom_range(0, 65535)) - 32768;
      w.output_voltage = vout[SAMPLE_WIDTH-1:0];
      case ($urandom_range(0, 3))
         0: w.battery_voltage = SAMPLE_WIDTH'($urandom);
         1: w.battery_voltage = clip_sample(vout + boundary_delta(battery_limit));
         2: w.battery_voltage = clip_sample(vout + int'($urandom_range(0, battery_limit))
                                            - int'(battery_limit) / 2);
         default: w.battery_voltage = w.output_voltage;
      endcase
      case ($urandom_range(0, 2))
         0: w.target_voltage = SAMPLE_WIDTH'($urandom);
         1: w.target_voltage = clip_sample(vout + boundary_delta(output_limit));
         default: w.target_voltage = w.output_voltage;
      endcase
      return w;
   endfunction

   task automatic run_random_phase();
      repeat (WORDS_PER_PHASE) pending_words.push_back(random_word());
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: table access at both ends of the index range,
      // a tick with every monitor failing and one with every monitor
      // passing, clear-all and the two undefined modes.
      push_access(MODE_WRITE, 4'd0, 8'hFF);
      push_access(MODE_READ, 4'd0, 8'h00);
      push_access(MODE_WRITE, 4'd15, 8'hA5);
      push_access(MODE_READ, 4'd15, 8'h00);
      push_access(MODE_SET, 4'd3, 8'h80);
      push_access(MODE_CLEAR, 4'd15, 8'h0F);
      push_access(MODE_READ, 4'd15, 8'h00);
      push_tick(6'h3F, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      push_access(MODE_READ, 4'd7, 8'h00);
      push_access(MODE_READ, 4'd2, 8'h00);
      push_tick(6'h00, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
      push_access(MODE_READ, 4'd7, 8'h00);
      push_access(MODE_CLEAR_ALL, 4'd0, 8'h00);
      push_access(MODE_SPARE_A, 4'd0, 8'hFF);
      push_access(MODE_SPARE_B, 4'd0, 8'hFF);
      push_access(MODE_READ, 4'd0, 8'h00);
      wait_drained();

      // Zero limits and no filtering: a one-count battery delta fails the
      // code at once, a zero output delta still passes.
      program_registers(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
      push_tick(6'h20, 16'sh0001, 16'sh0001, 16'sh0000, 16'sh0000);
      push_access(MODE_READ, 4'd5, 8'h00);
      push_access(MODE_READ, 4'd7, 8'h00);
      wait_drained();

      // Control disabled: ticks, set and clear leave the table alone while
      // write and clear-all still act.
      program_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      push_tick(6'h3F, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      push_access(MODE_SET, 4'd4, 8'hFF);
      push_access(MODE_READ, 4'd4, 8'h00);
      push_access(MODE_WRITE, 4'd4, 8'h3C);
      push_access(MODE_CLEAR, 4'd4, 8'hFF);
      push_access(MODE_READ, 4'd4, 8'h00);
      push_access(MODE_CLEAR_ALL, 4'd0, 8'h00);
      push_access(MODE_READ, 4'd4, 8'h00);
      wait_drained();

      // Random traffic under several register settings, the extremes among
      // them. The battery limit register gets its unused top bit set once.
      program_registers(16'd1, 16'd0, 16'd1024, 16'd128, 16'd3);
      run_random_phase();
      program_registers(16'd1, 16'h8000, 16'd0, 16'd0, 16'd0);
      run_random_phase();
      program_registers(16'd1, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      run_random_phase();
      program_registers(16'd0, CSR_DATA_WIDTH'($urandom_range(0, 65535)),
                        CSR_DATA_WIDTH'($urandom_range(0, 32767)),
                        CSR_DATA_WIDTH'($urandom_range(0, 32767)), 16'd5);
      run_random_phase();

      // Last phase runs at full rate on both sides.
      quiet_run = 1'b1;
      program_registers(16'd1, CSR_DATA_WIDTH'($urandom_range(0, 65535)),
                        CSR_DATA_WIDTH'($urandom_range(0, 4096)),
                        CSR_DATA_WIDTH'($urandom_range(0, 1024)),
                        CSR_DATA_WIDTH'($urandom_range(0, 8)));
      run_random_phase();
      repeat (8) @(negedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
